### rtl/plpt_pkg.sv
// Shared types, codes and defaults for the piecewise-linear path table.
`default_nettype none
package plpt_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int DIM_DEF        = 7;
  localparam int NUM_COORD      = 7;
  localparam int ADDR_MAX_W     = 12;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_STEP   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NONMONO  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic                  we;
    logic [ADDR_MAX_W-1:0] addr;
    logic                  cap_a;
    logic                  cap_b;
    logic                  start;
  } lane_ctl_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         tag;
    logic signed [31:0] pos;
    logic               zero_pt;
  } res_t;

endpackage
`default_nettype wire

### rtl/plpt_ram.sv
// Generic single-clock RAM with one write port and a registered read port.
`default_nettype none
module plpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/plpt_lane.sv
// One coordinate lane: node coordinate store and a multiply and shift-subtract interpolator.
`default_nettype none
module plpt_lane #(
  parameter int MAX_POINTS = plpt_pkg::MAX_POINTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire plpt_pkg::lane_ctl_t ctl,
  input  wire logic signed [31:0] wdata,
  input  wire logic signed [31:0] s0,
  input  wire logic signed [31:0] s1,
  input  wire logic signed [31:0] s,
  output logic                    done_r,
  output logic signed [31:0]      res_r
);

  localparam int AW = $clog2(MAX_POINTS);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_MUL  = 2'd1;
  localparam logic [1:0] L_DIV  = 2'd2;
  localparam logic [1:0] L_FIN  = 2'd3;

  logic [1:0]         st_r;
  logic [31:0]        rdata;
  logic signed [31:0] a_r, b_r;
  logic [31:0]        len_r, md_r, mo_r, rem_r;
  logic               neg_r;
  logic [63:0]        prod_r;
  logic [5:0]         cnt_r;

  logic signed [32:0] len33, diff33, off33;
  logic [32:0]        md33, mo33;
  logic               triv;
  logic [32:0]        rem_sh;
  logic               qbit;
  logic               over;
  logic [32:0]        qq;
  logic signed [33:0] sum34;
  logic signed [31:0] sat;

  plpt_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram (
    .clk    (clk),
    .we     (ctl.we),
    .waddr  (ctl.addr[AW-1:0]),
    .wdata  (wdata),
    .raddr  (ctl.addr[AW-1:0]),
    .rdata_r(rdata)
  );

  always_comb begin
    len33  = {s1[31], s1} - {s0[31], s0};
    diff33 = {b_r[31], b_r} - {a_r[31], a_r};
    off33  = {s[31], s} - {s0[31], s0};
    md33   = diff33[32] ? 33'(-diff33) : 33'(diff33);
    mo33   = off33[32] ? 33'(-off33) : 33'(off33);
    triv   = len33[32] || (len33 == '0) || (diff33 == '0) || (off33 == '0);
    rem_sh = {rem_r, prod_r[63]};
    qbit   = rem_sh >= {1'b0, len_r};
    over   = (|prod_r[63:33]) || (prod_r[32] && (|prod_r[31:0]));
    qq     = over ? 33'h1_0000_0000 : prod_r[32:0];
    sum34  = neg_r ? ({{2{a_r[31]}}, a_r} - {1'b0, qq}) : ({{2{a_r[31]}}, a_r} + {1'b0, qq});
    if (sum34 > 34'sh0_7FFF_FFFF) begin
      sat = 32'sh7FFF_FFFF;
    end else if (sum34 < -34'sh0_8000_0000) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = sum34[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b1;
    end else begin
      case (st_r)
        L_IDLE: begin
          if (ctl.start) begin
            done_r <= 1'b0;
            if (triv) begin
              res_r  <= a_r;
              done_r <= 1'b1;
            end else begin
              st_r <= L_MUL;
            end
          end
        end
        L_MUL: begin
          prod_r <= 64'(md_r) * 64'(mo_r);
          rem_r  <= '0;
          cnt_r  <= '0;
          st_r   <= L_DIV;
        end
        L_DIV: begin
          rem_r  <= qbit ? 32'(rem_sh - {1'b0, len_r}) : rem_sh[31:0];
          prod_r <= {prod_r[62:0], qbit};
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            st_r <= L_FIN;
          end
        end
        L_FIN: begin
          res_r  <= sat;
          done_r <= 1'b1;
          st_r   <= L_IDLE;
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_a) begin
      a_r <= rdata;
    end
    if (ctl.cap_b) begin
      b_r <= rdata;
    end
    if (ctl.start) begin
      len_r <= len33[31:0];
      md_r  <= md33[31:0];
      mo_r  <= mo33[31:0];
      neg_r <= diff33[32] != off33[32];
    end
  end

endmodule
`default_nettype wire

### rtl/plpt_merge.sv
// Merge stage: gathers lane results into the registered result beat.
`default_nettype none
module plpt_merge #(
  parameter int DIM = plpt_pkg::DIM_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               res_vld,
  input  wire plpt_pkg::res_t     res,
  input  wire logic signed [31:0] lane_val [DIM],
  output logic                    free,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic [7:0]              out_node_or_segment,
  output logic signed [31:0]      out_pos_s,
  output logic signed [31:0]      out_out_0,
  output logic signed [31:0]      out_out_1,
  output logic signed [31:0]      out_out_2,
  output logic signed [31:0]      out_out_3,
  output logic signed [31:0]      out_out_4,
  output logic signed [31:0]      out_out_5,
  output logic signed [31:0]      out_out_6
);

  logic               vld_r;
  plpt_pkg::res_t     hdr_r;
  logic signed [31:0] pt_r [plpt_pkg::NUM_COORD];

  assign free = !vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (free) begin
      vld_r <= res_vld;
    end
  end

  for (genvar k = 0; k < plpt_pkg::NUM_COORD; k++) begin : g_pt
    if (k < DIM) begin : g_on
      always_ff @(posedge clk) begin
        if (free && res_vld) begin
          pt_r[k] <= res.zero_pt ? 32'sd0 : lane_val[k];
        end
      end
    end else begin : g_off
      assign pt_r[k] = 32'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (free && res_vld) begin
      hdr_r <= res;
    end
  end

  assign out_valid           = vld_r;
  assign out_status          = hdr_r.status;
  assign out_node_or_segment = hdr_r.tag;
  assign out_pos_s           = hdr_r.pos;
  assign out_out_0           = pt_r[0];
  assign out_out_1           = pt_r[1];
  assign out_out_2           = pt_r[2];
  assign out_out_3           = pt_r[3];
  assign out_out_4           = pt_r[4];
  assign out_out_5           = pt_r[5];
  assign out_out_6           = pt_r[6];

endmodule
`default_nettype wire

### rtl/piecewise_linear_path_table.sv
// Top level: command sequencer, node parameter store, coordinate lanes and merge stage.
// Append, clear and commands on an empty table answer from dispatch; lookup and step interpolate,
// a lookup after scanning the nodes; one node, or a step clamped to the end, copies a node instead.
// The interpolators multiply, then divide one quotient bit a cycle; one item in work at a time.
// Throughput: the next beat is taken the cycle after the result enters the output register.
// Reset empties the table and clears position and segment; node memories are not cleared.
`default_nettype none
module piecewise_linear_path_table #(
  parameter int MAX_POINTS = plpt_pkg::MAX_POINTS_DEF,
  parameter int DIM        = plpt_pkg::DIM_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_command,
  input  wire logic signed [31:0] in_param_s,
  input  wire logic signed [31:0] in_coord_0,
  input  wire logic signed [31:0] in_coord_1,
  input  wire logic signed [31:0] in_coord_2,
  input  wire logic signed [31:0] in_coord_3,
  input  wire logic signed [31:0] in_coord_4,
  input  wire logic signed [31:0] in_coord_5,
  input  wire logic signed [31:0] in_coord_6,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic [7:0]              out_node_or_segment,
  output logic signed [31:0]      out_pos_s,
  output logic signed [31:0]      out_out_0,
  output logic signed [31:0]      out_out_1,
  output logic signed [31:0]      out_out_2,
  output logic signed [31:0]      out_out_3,
  output logic signed [31:0]      out_out_4,
  output logic signed [31:0]      out_out_5,
  output logic signed [31:0]      out_out_6
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CMP = 4'd3;
  localparam logic [3:0] S_SEG_RD   = 4'd4;
  localparam logic [3:0] S_SEG_CMP  = 4'd5;
  localparam logic [3:0] S_RD0      = 4'd6;
  localparam logic [3:0] S_RD1      = 4'd7;
  localparam logic [3:0] S_RD2      = 4'd8;
  localparam logic [3:0] S_COPY     = 4'd9;
  localparam logic [3:0] S_COPY_CAP = 4'd10;
  localparam logic [3:0] S_START    = 4'd11;
  localparam logic [3:0] S_WAIT     = 4'd12;
  localparam logic [3:0] S_OUT      = 4'd13;

  logic [3:0]         st_r;
  logic [1:0]         cmd_r;
  logic signed [31:0] p_r;
  logic signed [31:0] crd_r [plpt_pkg::NUM_COORD];
  logic [CW-1:0]      count_r;
  logic [AW-1:0]      seg_r, idx_r, c_r;
  logic signed [31:0] cur_r, last_s_r, s_r, s0_r, s1_r;
  plpt_pkg::res_t     res_r;

  logic                   pr_we;
  logic [AW-1:0]          pr_addr;
  logic signed [31:0]     pr_wdata, pr_rdata;
  plpt_pkg::lane_ctl_t    lctl;
  logic signed [31:0]     lane_val [DIM];
  logic [DIM-1:0]         lane_done;
  logic                   free;

  logic [CW-1:0]      end_c;
  logic               app_rej, app_full;
  logic signed [32:0] mag33, sum33;
  logic signed [31:0] step_s;
  logic [CW-1:0]      idx_c, c_next;
  logic [AW+7:0]      count_ext, seg_ext;
  logic [AW-1:0]      step_idx;

  assign in_stall = st_r != S_IDLE;

  always_comb begin
    end_c     = count_r - CW'(1);
    app_rej   = (count_r != '0) && (last_s_r > p_r);
    app_full  = count_r == CW'(MAX_POINTS);
    mag33     = p_r[31] ? -{p_r[31], p_r} : {p_r[31], p_r};
    sum33     = {p_r[31], p_r} + {cur_r[31], cur_r};
    if (sum33 > 33'sh0_7FFF_FFFF) begin
      step_s = 32'sh7FFF_FFFF;
    end else if (sum33 < -33'sh0_8000_0000) begin
      step_s = 32'sh8000_0000;
    end else begin
      step_s = sum33[31:0];
    end
    if (seg_r == '0) begin
      step_idx = AW'(1);
    end else if (CW'(seg_r) > end_c) begin
      step_idx = end_c[AW-1:0];
    end else begin
      step_idx = seg_r;
    end
    idx_c     = CW'(idx_r);
    c_next    = CW'(c_r) + CW'(1);
    count_ext = {8'd0, count_r[AW-1:0]};
    seg_ext   = {8'd0, seg_r};
  end

  always_comb begin
    lctl     = '0;
    pr_we    = 1'b0;
    pr_addr  = idx_r;
    pr_wdata = (count_r == '0) ? 32'sd0 : p_r;
    case (st_r)
      S_DISP: begin
        pr_addr = count_r[AW-1:0];
        if (cmd_r == plpt_pkg::CMD_APPEND && !app_rej && !app_full) begin
          pr_we   = 1'b1;
          lctl.we = 1'b1;
        end
        lctl.addr = plpt_pkg::ADDR_MAX_W'(count_r[AW-1:0]);
      end
      S_SCAN_RD: pr_addr = c_r;
      S_SEG_RD:  pr_addr = idx_r;
      S_RD0: begin
        pr_addr   = idx_r - AW'(1);
        lctl.addr = plpt_pkg::ADDR_MAX_W'(idx_r - AW'(1));
      end
      S_RD1: begin
        lctl.addr  = plpt_pkg::ADDR_MAX_W'(idx_r);
        lctl.cap_a = 1'b1;
      end
      S_RD2:      lctl.cap_b = 1'b1;
      S_COPY:     lctl.addr  = plpt_pkg::ADDR_MAX_W'(idx_r);
      S_COPY_CAP: lctl.cap_a = 1'b1;
      S_START:    lctl.start = 1'b1;
      default: ;
    endcase
  end

  plpt_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_param (
    .clk    (clk),
    .we     (pr_we),
    .waddr  (pr_addr),
    .wdata  (pr_wdata),
    .raddr  (pr_addr),
    .rdata_r(pr_rdata)
  );

  for (genvar k = 0; k < DIM; k++) begin : g_lane
    plpt_lane #(.MAX_POINTS(MAX_POINTS)) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lctl),
      .wdata (crd_r[k]),
      .s0    (s0_r),
      .s1    (s1_r),
      .s     (s_r),
      .done_r(lane_done[k]),
      .res_r (lane_val[k])
    );
  end

  plpt_merge #(.DIM(DIM)) u_merge (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_vld            (st_r == S_OUT),
    .res                (res_r),
    .lane_val           (lane_val),
    .free               (free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_node_or_segment(out_node_or_segment),
    .out_pos_s          (out_pos_s),
    .out_out_0          (out_out_0),
    .out_out_1          (out_out_1),
    .out_out_2          (out_out_2),
    .out_out_3          (out_out_3),
    .out_out_4          (out_out_4),
    .out_out_5          (out_out_5),
    .out_out_6          (out_out_6)
  );

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_valid) begin
      cmd_r    <= in_command;
      p_r      <= in_param_s;
      crd_r[0] <= in_coord_0;
      crd_r[1] <= in_coord_1;
      crd_r[2] <= in_coord_2;
      crd_r[3] <= in_coord_3;
      crd_r[4] <= in_coord_4;
      crd_r[5] <= in_coord_5;
      crd_r[6] <= in_coord_6;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      count_r <= '0;
      seg_r   <= '0;
      cur_r   <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            st_r <= S_DISP;
          end
        end
        S_DISP: begin
          res_r.zero_pt <= 1'b1;
          res_r.status  <= plpt_pkg::ST_OK;
          res_r.tag     <= '0;
          res_r.pos     <= cur_r;
          st_r          <= S_OUT;
          if (cmd_r == plpt_pkg::CMD_APPEND) begin
            if (app_rej) begin
              res_r.status <= plpt_pkg::ST_NONMONO;
            end else if (app_full) begin
              res_r.status <= plpt_pkg::ST_FULL;
            end else begin
              res_r.tag <= count_ext[7:0];
              last_s_r  <= pr_wdata;
              count_r   <= count_r + CW'(1);
            end
          end else if (cmd_r == plpt_pkg::CMD_CLEAR) begin
            count_r   <= '0;
            seg_r     <= '0;
            cur_r     <= '0;
            res_r.pos <= '0;
          end else if (count_r == '0) begin
            seg_r        <= '0;
            cur_r        <= '0;
            res_r.pos    <= '0;
            res_r.status <= plpt_pkg::ST_EMPTY;
          end else if (count_r == CW'(1)) begin
            seg_r <= '0;
            cur_r <= '0;
            idx_r <= '0;
            st_r  <= S_COPY;
          end else if (cmd_r == plpt_pkg::CMD_LOOKUP) begin
            s_r <= p_r;
            if (mag33 > {last_s_r[31], last_s_r}) begin
              idx_r <= end_c[AW-1:0];
              st_r  <= S_RD0;
            end else if (!p_r[31] && p_r != '0) begin
              c_r <= AW'(1);
              if (CW'(1) < end_c) begin
                st_r <= S_SCAN_RD;
              end else begin
                idx_r <= end_c[AW-1:0];
                st_r  <= S_RD0;
              end
            end else begin
              idx_r <= AW'(1);
              st_r  <= S_RD0;
            end
          end else begin
            s_r   <= step_s;
            idx_r <= step_idx;
            st_r  <= S_SEG_RD;
          end
        end
        S_SCAN_RD: st_r <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (p_r < pr_rdata) begin
            idx_r <= c_r;
            st_r  <= S_RD0;
          end else if (c_next < end_c) begin
            c_r  <= c_next[AW-1:0];
            st_r <= S_SCAN_RD;
          end else begin
            idx_r <= end_c[AW-1:0];
            st_r  <= S_RD0;
          end
        end
        S_SEG_RD: st_r <= S_SEG_CMP;
        S_SEG_CMP: begin
          if (s_r > pr_rdata && idx_c >= end_c) begin
            idx_r <= end_c[AW-1:0];
            seg_r <= end_c[AW-1:0];
            cur_r <= last_s_r;
            st_r  <= S_COPY;
          end else begin
            if (s_r > pr_rdata) begin
              idx_r <= idx_r + AW'(1);
            end
            st_r <= S_RD0;
          end
        end
        S_RD0: begin
          seg_r <= idx_r;
          cur_r <= s_r;
          st_r  <= S_RD1;
        end
        S_RD1: begin
          s0_r <= pr_rdata;
          st_r <= S_RD2;
        end
        S_RD2: begin
          s1_r <= pr_rdata;
          st_r <= S_START;
        end
        S_COPY: st_r <= S_COPY_CAP;
        S_COPY_CAP: begin
          s0_r <= '0;
          s1_r <= '0;
          st_r <= S_START;
        end
        S_START: st_r <= S_WAIT;
        S_WAIT: begin
          if (&lane_done) begin
            res_r.zero_pt <= 1'b0;
            res_r.status  <= plpt_pkg::ST_OK;
            res_r.tag     <= seg_ext[7:0];
            res_r.pos     <= cur_r;
            st_r          <= S_OUT;
          end
        end
        S_OUT: begin
          if (free) begin
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
